// ===== design/rcf_pkg.sv =====
// ============================================================================
// rcf_pkg
// Shared types, widths, constants and helpers for the raceline cubic fit.
// ============================================================================
package rcf_pkg;

    // Field widths
    localparam int COORD_W = 32;              // Q16.16 coordinates and slopes
    localparam int DIFF_W  = COORD_W + 1;     // blue - yellow
    localparam int FRAC_W  = 17;              // Q1.16 fractions, up to 1.99
    localparam int PT_W    = 52;              // blended point at scale 2^-32
    localparam int SL_W    = 48;              // slope average at scale 2^-32
    localparam int ACC_W   = 64;              // dot product at scale 2^-36
    localparam int COEF_W  = 48;              // Q30.18 coefficient
    localparam int RND_SH  = 18;              // 2^-36 -> 2^-18
    localparam int ROWS    = 8;
    localparam int HALF_ROWS = 4;

    // Configuration
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_FRAC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MID_FRAC   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_FRAC   = 2'd2;
    localparam logic [FRAC_W-1:0]    FRAC_RESET     = 17'd32768;

    // Default depth of the request queue between front and back
    localparam int Q_DEPTH = 4;

    // Fit matrix, every entry scaled by 16
    localparam int FIT_M [ROWS][ROWS] = '{
        '{ 160, -160,  -96,   96,   48,  -16,  32,  4},
        '{-144,  144,   48,  -48,  -56,    8, -16, -2},
        '{   0,    0,    0,    0,   16,    0,   0,  0},
        '{  16,    0,    0,    0,    0,    0,   0,  0},
        '{ -96,   96,  160, -160,  -16,   48, -32,  4},
        '{  96,  -96,  -96,   96,   16,  -16,  32, -4},
        '{ -24,   24,  -24,   24,   -4,   -4,  -8,  1},
        '{   0,    0,   16,    0,    0,    0,   0,  0}
    };

    // One classified request: the fit's input vector, duplicates dropped
    typedef struct packed {
        logic                   axis;
        logic signed [PT_W-1:0] p0;
        logic signed [PT_W-1:0] p1;
        logic signed [PT_W-1:0] p2;
        logic signed [SL_W-1:0] k;
        logic signed [SL_W-1:0] l;
    } t_vec;

    // Back-end sequencer
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FIRST,
        BK_SECOND
    } t_bk_state;

    // yellow*2^16 + frac*(blue - yellow)
    function automatic logic signed [PT_W-1:0] blend(
        input logic signed [DIFF_W-1:0]  diff,
        input logic signed [COORD_W-1:0] yel,
        input logic        [FRAC_W-1:0]  frac
    );
        logic signed [FRAC_W:0]                f;
        logic signed [FRAC_W+DIFF_W:0]         prod;
        logic signed [PT_W-1:0]                base;
        f    = $signed({1'b0, frac});
        prod = f * diff;
        base = $signed({{(PT_W-COORD_W-16){yel[COORD_W-1]}}, yel, 16'd0});
        return base + $signed({{(PT_W-FRAC_W-DIFF_W-1){prod[FRAC_W+DIFF_W]}}, prod});
    endfunction

endpackage

// ===== design/rcf_front.sv =====
// ============================================================================
// rcf_front
// Accepts requests, holds the fraction registers and forms the fit vector.
// ============================================================================
module rcf_front import rcf_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_req,
    input  logic                      i_axis,
    input  logic signed [COORD_W-1:0] i_blue_start,
    input  logic signed [COORD_W-1:0] i_yellow_start,
    input  logic signed [COORD_W-1:0] i_blue_mid,
    input  logic signed [COORD_W-1:0] i_yellow_mid,
    input  logic signed [COORD_W-1:0] i_blue_end,
    input  logic signed [COORD_W-1:0] i_yellow_end,
    input  logic signed [COORD_W-1:0] i_blue_slope_start,
    input  logic signed [COORD_W-1:0] i_blue_slope_end,
    input  logic signed [COORD_W-1:0] i_yellow_slope_start,
    input  logic signed [COORD_W-1:0] i_yellow_slope_end,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [FRAC_W-1:0]         i_cfg_data,
    output logic                      o_push,
    output t_vec                      o_vec,
    output logic [1:0]                o_inflight
);

    logic [FRAC_W-1:0]         r_frac_s, r_frac_m, r_frac_e;

    logic                      r_s1_v;
    logic                      r_s1_axis;
    logic signed [DIFF_W-1:0]  r_s1_ds, r_s1_dm, r_s1_de;
    logic signed [COORD_W-1:0] r_s1_ys, r_s1_ym, r_s1_ye;
    logic signed [DIFF_W-1:0]  r_s1_ksum, r_s1_lsum;

    logic                      r_s2_v;
    t_vec                      r_s2_vec;
    t_vec                      n_s2_vec;

    // Fraction registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac_s <= FRAC_RESET;
            r_frac_m <= FRAC_RESET;
            r_frac_e <= FRAC_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_FRAC: r_frac_s <= i_cfg_data;
                CFG_MID_FRAC:   r_frac_m <= i_cfg_data;
                CFG_END_FRAC:   r_frac_e <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage 1: gaps and slope sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req) begin
            r_s1_axis <= i_axis;
            r_s1_ds   <= DIFF_W'(i_blue_start) - DIFF_W'(i_yellow_start);
            r_s1_dm   <= DIFF_W'(i_blue_mid) - DIFF_W'(i_yellow_mid);
            r_s1_de   <= DIFF_W'(i_blue_end) - DIFF_W'(i_yellow_end);
            r_s1_ys   <= i_yellow_start;
            r_s1_ym   <= i_yellow_mid;
            r_s1_ye   <= i_yellow_end;
            r_s1_ksum <= DIFF_W'(i_blue_slope_start) + DIFF_W'(i_blue_slope_end);
            r_s1_lsum <= DIFF_W'(i_yellow_slope_start) + DIFF_W'(i_yellow_slope_end);
        end
    end

    // Stage 2: one multiplier per point, slope sums scaled by 2^15
    always_comb begin
        n_s2_vec.axis = r_s1_axis;
        n_s2_vec.p0   = blend(r_s1_ds, r_s1_ys, r_frac_s);
        n_s2_vec.p1   = blend(r_s1_dm, r_s1_ym, r_frac_m);
        n_s2_vec.p2   = blend(r_s1_de, r_s1_ye, r_frac_e);
        n_s2_vec.k    = $signed({r_s1_ksum, 15'd0});
        n_s2_vec.l    = $signed({r_s1_lsum, 15'd0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_v) begin
            r_s2_vec <= n_s2_vec;
        end
    end

    assign o_push     = r_s2_v;
    assign o_vec      = r_s2_vec;
    assign o_inflight = {1'b0, r_s1_v} + {1'b0, r_s2_v};

endmodule

// ===== design/rcf_queue.sv =====
// ============================================================================
// rcf_queue
// Short request queue between the front and the back.
// ============================================================================
module rcf_queue import rcf_pkg::*; #(
    parameter int DEPTH = Q_DEPTH,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  t_vec             i_data,
    input  logic             i_pop,
    output t_vec             o_head,
    output logic             o_empty,
    output logic [CNT_W-1:0] o_count
);

    localparam int PTR_W = $clog2(DEPTH);

    t_vec             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

// ===== design/rcf_back.sv =====
// ============================================================================
// rcf_back
// Runs the fit matrix over a request, one half per cycle, rounds and clamps.
// ============================================================================
module rcf_back import rcf_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_vec                     i_head,
    input  logic                     i_empty,
    output logic                     o_pop,
    output logic                     o_valid,
    output logic                     o_axis_out,
    output logic                     o_half,
    output logic signed [COEF_W-1:0] o_coef_a,
    output logic signed [COEF_W-1:0] o_coef_b,
    output logic signed [COEF_W-1:0] o_coef_c,
    output logic signed [COEF_W-1:0] o_coef_d,
    output logic                     o_last
);

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (RND_SH - 1);

    t_bk_state               r_state, n_state;
    t_vec                    r_cur;
    logic                    calc_v, calc_half;

    logic signed [ACC_W-1:0] b_vec [ROWS];
    logic signed [ACC_W-1:0] n_lo [HALF_ROWS];
    logic signed [ACC_W-1:0] n_hi [HALF_ROWS];
    logic signed [ACC_W-1:0] r_lo [HALF_ROWS];
    logic signed [ACC_W-1:0] r_hi [HALF_ROWS];
    logic                    r_b1_v, r_b1_half, r_b1_axis;

    logic signed [COEF_W-1:0] n_coef [HALF_ROWS];
    logic signed [COEF_W-1:0] r_coef [HALF_ROWS];
    logic                     r_valid, r_half, r_axis;

    // Sequencer: next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE:   n_state = i_empty ? BK_IDLE : BK_FIRST;
            BK_FIRST:  n_state = BK_SECOND;
            BK_SECOND: n_state = i_empty ? BK_IDLE : BK_FIRST;
            default:   n_state = BK_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb begin
        o_pop     = 1'b0;
        calc_v    = 1'b0;
        calc_half = 1'b0;
        case (r_state)
            BK_IDLE: begin
                o_pop = !i_empty;
            end
            BK_FIRST: begin
                calc_v = 1'b1;
            end
            BK_SECOND: begin
                calc_v    = 1'b1;
                calc_half = 1'b1;
                o_pop     = !i_empty;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Current request
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_head;
        end
    end

    // Input vector [p0, p1, p1, p2, k, l, 0, 0]
    always_comb begin
        b_vec[0] = $signed({{(ACC_W-PT_W){r_cur.p0[PT_W-1]}}, r_cur.p0});
        b_vec[1] = $signed({{(ACC_W-PT_W){r_cur.p1[PT_W-1]}}, r_cur.p1});
        b_vec[2] = b_vec[1];
        b_vec[3] = $signed({{(ACC_W-PT_W){r_cur.p2[PT_W-1]}}, r_cur.p2});
        b_vec[4] = $signed({{(ACC_W-SL_W){r_cur.k[SL_W-1]}}, r_cur.k});
        b_vec[5] = $signed({{(ACC_W-SL_W){r_cur.l[SL_W-1]}}, r_cur.l});
        b_vec[6] = '0;
        b_vec[7] = '0;
    end

    // Stage B1: constant-coefficient partial sums, four rows of one half
    always_comb begin
        for (int j = 0; j < HALF_ROWS; j++) begin
            n_lo[j] = '0;
            n_hi[j] = '0;
            for (int c = 0; c < ROWS / 2; c++) begin
                // fixed coefficients per row, half picks the row set
                if (calc_half) begin
                    n_lo[j] = n_lo[j]
                        + ACC_W'(FIT_M[j + HALF_ROWS][c]) * b_vec[c];
                    n_hi[j] = n_hi[j]
                        + ACC_W'(FIT_M[j + HALF_ROWS][c + ROWS / 2])
                        * b_vec[c + ROWS / 2];
                end else begin
                    n_lo[j] = n_lo[j]
                        + ACC_W'(FIT_M[j][c]) * b_vec[c];
                    n_hi[j] = n_hi[j]
                        + ACC_W'(FIT_M[j][c + ROWS / 2])
                        * b_vec[c + ROWS / 2];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v <= 1'b0;
        end else begin
            r_b1_v <= calc_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (calc_v) begin
            r_b1_half <= calc_half;
            r_b1_axis <= r_cur.axis;
            r_lo      <= n_lo;
            r_hi      <= n_hi;
        end
    end

    // Stage B2: final add, round half up, clamp to Q30.18
    always_comb begin
        for (int j = 0; j < HALF_ROWS; j++) begin
            logic signed [ACC_W-1:0] acc;
            logic signed [ACC_W-1:0] q;
            acc = r_lo[j] + r_hi[j] + ROUND_HALF;
            q   = acc >>> RND_SH;
            if ((&q[ACC_W-1:COEF_W-1]) || !(|q[ACC_W-1:COEF_W-1])) begin
                n_coef[j] = q[COEF_W-1:0];
            end else if (q[ACC_W-1]) begin
                n_coef[j] = {1'b1, {(COEF_W-1){1'b0}}};
            end else begin
                n_coef[j] = {1'b0, {(COEF_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_b1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b1_v) begin
            r_half <= r_b1_half;
            r_axis <= r_b1_axis;
            r_coef <= n_coef;
        end
    end

    assign o_valid    = r_valid;
    assign o_axis_out = r_axis;
    assign o_half     = r_half;
    assign o_last     = r_half;
    assign o_coef_a   = r_coef[0];
    assign o_coef_b   = r_coef[1];
    assign o_coef_c   = r_coef[2];
    assign o_coef_d   = r_coef[3];

endmodule

// ===== design/two_piece_cubic_raceline_fit.sv =====
// ============================================================================
// two_piece_cubic_raceline_fit
// A request passes the front stages, the queue and the back stages B1 and B2;
// the second result of a request strobes in the cycle right after the first.
// The back end produces one half per cycle and pops the next queued request
// while it computes the second half; busy rises once QUEUE_DEPTH requests sit
// in the front stages and the queue together.
// Reset (synchronous, active low) empties the queue and front stages and sets
// all three fractions to one half. Results cannot be stalled by the receiver.
// ============================================================================
module two_piece_cubic_raceline_fit import rcf_pkg::*; #(
    parameter int QUEUE_DEPTH = Q_DEPTH     // 2 or more
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_axis,
    input  logic signed [COORD_W-1:0] i_blue_start,
    input  logic signed [COORD_W-1:0] i_yellow_start,
    input  logic signed [COORD_W-1:0] i_blue_mid,
    input  logic signed [COORD_W-1:0] i_yellow_mid,
    input  logic signed [COORD_W-1:0] i_blue_end,
    input  logic signed [COORD_W-1:0] i_yellow_end,
    input  logic signed [COORD_W-1:0] i_blue_slope_start,
    input  logic signed [COORD_W-1:0] i_blue_slope_end,
    input  logic signed [COORD_W-1:0] i_yellow_slope_start,
    input  logic signed [COORD_W-1:0] i_yellow_slope_end,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [FRAC_W-1:0]         i_cfg_data,
    output logic                      o_valid,
    output logic                      o_axis_out,
    output logic                      o_half,
    output logic signed [COEF_W-1:0]  o_coef_a,
    output logic signed [COEF_W-1:0]  o_coef_b,
    output logic signed [COEF_W-1:0]  o_coef_c,
    output logic signed [COEF_W-1:0]  o_coef_d,
    output logic                      o_last
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 3);

    logic             req;
    logic             push, pop, q_empty;
    t_vec             push_vec, q_head;
    logic [1:0]       inflight;
    logic [CNT_W-1:0] q_count;
    logic [OCC_W-1:0] occ;

    // Requests not yet handed to the back end
    assign occ  = OCC_W'(q_count) + OCC_W'(inflight);
    assign busy = (occ >= OCC_W'(QUEUE_DEPTH));
    assign req  = start && !busy;

    rcf_front u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_req                (req),
        .i_axis               (i_axis),
        .i_blue_start         (i_blue_start),
        .i_yellow_start       (i_yellow_start),
        .i_blue_mid           (i_blue_mid),
        .i_yellow_mid         (i_yellow_mid),
        .i_blue_end           (i_blue_end),
        .i_yellow_end         (i_yellow_end),
        .i_blue_slope_start   (i_blue_slope_start),
        .i_blue_slope_end     (i_blue_slope_end),
        .i_yellow_slope_start (i_yellow_slope_start),
        .i_yellow_slope_end   (i_yellow_slope_end),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .o_push               (push),
        .o_vec                (push_vec),
        .o_inflight           (inflight)
    );

    rcf_queue #(
        .DEPTH (QUEUE_DEPTH),
        .CNT_W (CNT_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_vec),
        .i_pop   (pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    rcf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (q_head),
        .i_empty    (q_empty),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .o_axis_out (o_axis_out),
        .o_half     (o_half),
        .o_coef_a   (o_coef_a),
        .o_coef_b   (o_coef_b),
        .o_coef_c   (o_coef_c),
        .o_coef_d   (o_coef_d),
        .o_last     (o_last)
    );

endmodule

// ===== design/rcf_checker.sv =====
// ============================================================================
// rcf_checker
// Port-level checks on result pairing and busy behavior.
// ============================================================================
module rcf_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid,
    input logic o_half,
    input logic o_axis_out,
    input logic o_last
);

    // A first-half result is always followed at once by its second half
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_half) |=> (o_valid && o_half))
        else $error("second half did not follow first half");

    // A second-half result is always preceded by its first half
    a_pair_precedes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_half) |-> ($past(o_valid) && !$past(o_half)))
        else $error("second half without first half");

    // Both halves of a pair carry the same axis
    a_pair_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_half) |-> (o_axis_out == $past(o_axis_out)))
        else $error("axis changed within a result pair");

    // Last marks the second half
    a_last_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == o_half))
        else $error("last flag does not match half");

    // Nothing is pending in the cycle after a reset edge
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_valid))
        else $error("busy or result right after reset");

endmodule

bind two_piece_cubic_raceline_fit rcf_checker u_rcf_checker (.*);

// ===== dv/fit_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fit_scoreboard_pkg
// Request and result types plus the scoreboard for the raceline cubic fit.
// Keeps its own copy of the three fraction registers and predicts both cubic
// pieces of every accepted request in exact 64-bit arithmetic.
// ============================================================================
package fit_scoreboard_pkg;
    import rcf_pkg::*;

    // One request: one axis of a track chunk
    typedef struct packed {
        logic                      axis;
        logic signed [COORD_W-1:0] blue_start;
        logic signed [COORD_W-1:0] yellow_start;
        logic signed [COORD_W-1:0] blue_mid;
        logic signed [COORD_W-1:0] yellow_mid;
        logic signed [COORD_W-1:0] blue_end;
        logic signed [COORD_W-1:0] yellow_end;
        logic signed [COORD_W-1:0] blue_slope_start;
        logic signed [COORD_W-1:0] blue_slope_end;
        logic signed [COORD_W-1:0] yellow_slope_start;
        logic signed [COORD_W-1:0] yellow_slope_end;
    } t_chunk;

    // One cubic piece as seen on the result ports
    typedef struct packed {
        logic                     axis_out;
        logic                     half;
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic signed [COEF_W-1:0] coef_c;
        logic signed [COEF_W-1:0] coef_d;
        logic                     last;
    } t_piece;

    localparam longint Q30_18_HI = 64'sd140737488355327;
    localparam longint Q30_18_LO = -64'sd140737488355328;

    // Inverse fit matrix times 16
    localparam longint SPLINE_INV16 [8][8] = '{
        '{ 160, -160,  -96,   96,   48,  -16,  32,  4},
        '{-144,  144,   48,  -48,  -56,    8, -16, -2},
        '{   0,    0,    0,    0,   16,    0,   0,  0},
        '{  16,    0,    0,    0,    0,    0,   0,  0},
        '{ -96,   96,  160, -160,  -16,   48, -32,  4},
        '{  96,  -96,  -96,   96,   16,  -16,  32, -4},
        '{ -24,   24,  -24,   24,   -4,   -4,  -8,  1},
        '{   0,    0,   16,    0,    0,    0,   0,  0}
    };

    class coef_scoreboard;
        logic [FRAC_W-1:0] start_frac;
        logic [FRAC_W-1:0] mid_frac;
        logic [FRAC_W-1:0] end_frac;
        t_piece            pending_pieces[$];
        int unsigned       errors;

        function new();
            start_frac = FRAC_RESET;
            mid_frac   = FRAC_RESET;
            end_frac   = FRAC_RESET;
            errors     = 0;
        endfunction

        // Mirror of a register write; unknown indexes are dropped
        function void write_fraction(logic [CFG_IDX_W-1:0] idx, logic [FRAC_W-1:0] val);
            case (idx)
                CFG_START_FRAC: start_frac = val;
                CFG_MID_FRAC:   mid_frac   = val;
                CFG_END_FRAC:   end_frac   = val;
                default: ;
            endcase
        endfunction

        static function longint widen(logic [COORD_W-1:0] v);
            return longint'($signed(v));
        endfunction

        // yellow + d*(blue - yellow) at scale 2^-32
        static function longint raceline_point(logic [COORD_W-1:0] blue,
                                               logic [COORD_W-1:0] yellow,
                                               logic [FRAC_W-1:0] frac);
            return widen(yellow) * 65536 + longint'(frac) * (widen(blue) - widen(yellow));
        endfunction

        // scale 2^-36 -> Q30.18, half rounds up, then clamp
        static function logic signed [COEF_W-1:0] to_q30_18(longint acc);
            longint q;
            q = (acc + 64'sd131072) >>> RND_SH;
            if (q > Q30_18_HI) q = Q30_18_HI;
            if (q < Q30_18_LO) q = Q30_18_LO;
            return q[COEF_W-1:0];
        endfunction

        // Predict both pieces of an accepted request
        function void note_chunk(t_chunk c);
            longint                   vec [8];
            longint                   acc;
            logic signed [COEF_W-1:0] coef [4];
            t_piece                   piece;
            vec[0] = raceline_point(c.blue_start, c.yellow_start, start_frac);
            vec[1] = raceline_point(c.blue_mid, c.yellow_mid, mid_frac);
            vec[2] = vec[1];
            vec[3] = raceline_point(c.blue_end, c.yellow_end, end_frac);
            vec[4] = (widen(c.blue_slope_start) + widen(c.blue_slope_end)) * 32768;
            vec[5] = (widen(c.yellow_slope_start) + widen(c.yellow_slope_end)) * 32768;
            vec[6] = 0;
            vec[7] = 0;
            for (int h = 0; h < 2; h++) begin
                for (int r = 0; r < HALF_ROWS; r++) begin
                    acc = 0;
                    for (int j = 0; j < ROWS; j++)
                        acc += SPLINE_INV16[h*HALF_ROWS+r][j] * vec[j];
                    coef[r] = to_q30_18(acc);
                end
                piece.axis_out = c.axis;
                piece.half     = (h == 1);
                piece.coef_a   = coef[0];
                piece.coef_b   = coef[1];
                piece.coef_c   = coef[2];
                piece.coef_d   = coef[3];
                piece.last     = (h == 1);
                pending_pieces = {pending_pieces, piece};
            end
        endfunction

        function void report(string field, logic [COEF_W-1:0] want, logic [COEF_W-1:0] got);
            errors++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
        endfunction

        // Compare a result with the oldest prediction
        function void check_piece(t_piece got);
            t_piece want;
            if (pending_pieces.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual half=%0d a=%h",
                         $time, got.half, got.coef_a);
                return;
            end
            want = pending_pieces.pop_front();
            if (got.axis_out !== want.axis_out)
                report("axis_out", COEF_W'(want.axis_out), COEF_W'(got.axis_out));
            if (got.half !== want.half)
                report("half", COEF_W'(want.half), COEF_W'(got.half));
            if (got.coef_a !== want.coef_a)     report("coef_a", want.coef_a, got.coef_a);
            if (got.coef_b !== want.coef_b)     report("coef_b", want.coef_b, got.coef_b);
            if (got.coef_c !== want.coef_c)     report("coef_c", want.coef_c, got.coef_c);
            if (got.coef_d !== want.coef_d)     report("coef_d", want.coef_d, got.coef_d);
            if (got.last !== want.last)
                report("last", COEF_W'(want.last), COEF_W'(got.last));
        endfunction
    endclass

endpackage

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Drives axis requests into the two-piece raceline fit and checks every cubic
// piece against a scoreboard prediction. Directed corner requests first, then
// random track-like, full-range and corner requests over several fraction
// settings, with random sender gaps, bursts and full drains.
// ============================================================================
module testbench;
    import rcf_pkg::*;
    import fit_scoreboard_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;   // unmapped index
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 250;
    localparam int DIRECTED_N  = 20;
    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'd65536;
    localparam logic [FRAC_W-1:0] FRAC_MAX = 17'd131071;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic                      i_axis = 1'b0;
    logic signed [COORD_W-1:0] i_blue_start = '0;
    logic signed [COORD_W-1:0] i_yellow_start = '0;
    logic signed [COORD_W-1:0] i_blue_mid = '0;
    logic signed [COORD_W-1:0] i_yellow_mid = '0;
    logic signed [COORD_W-1:0] i_blue_end = '0;
    logic signed [COORD_W-1:0] i_yellow_end = '0;
    logic signed [COORD_W-1:0] i_blue_slope_start = '0;
    logic signed [COORD_W-1:0] i_blue_slope_end = '0;
    logic signed [COORD_W-1:0] i_yellow_slope_start = '0;
    logic signed [COORD_W-1:0] i_yellow_slope_end = '0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_idx = '0;
    logic [FRAC_W-1:0]         i_cfg_data = '0;
    logic                      o_valid;
    logic                      o_axis_out;
    logic                      o_half;
    logic signed [COEF_W-1:0]  o_coef_a;
    logic signed [COEF_W-1:0]  o_coef_b;
    logic signed [COEF_W-1:0]  o_coef_c;
    logic signed [COEF_W-1:0]  o_coef_d;
    logic                      o_last;

    coef_scoreboard sb;
    t_piece         seen_piece;

    two_piece_cubic_raceline_fit DUT (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_axis               (i_axis),
        .i_blue_start         (i_blue_start),
        .i_yellow_start       (i_yellow_start),
        .i_blue_mid           (i_blue_mid),
        .i_yellow_mid         (i_yellow_mid),
        .i_blue_end           (i_blue_end),
        .i_yellow_end         (i_yellow_end),
        .i_blue_slope_start   (i_blue_slope_start),
        .i_blue_slope_end     (i_blue_slope_end),
        .i_yellow_slope_start (i_yellow_slope_start),
        .i_yellow_slope_end   (i_yellow_slope_end),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .o_valid              (o_valid),
        .o_axis_out           (o_axis_out),
        .o_half               (o_half),
        .o_coef_a             (o_coef_a),
        .o_coef_b             (o_coef_b),
        .o_coef_c             (o_coef_c),
        .o_coef_d             (o_coef_d),
        .o_last               (o_last)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result monitor: outputs sampled at the edge that ends the strobe cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            seen_piece.axis_out = o_axis_out;
            seen_piece.half     = o_half;
            seen_piece.coef_a   = o_coef_a;
            seen_piece.coef_b   = o_coef_b;
            seen_piece.coef_c   = o_coef_c;
            seen_piece.coef_d   = o_coef_d;
            seen_piece.last     = o_last;
            sb.check_piece(seen_piece);
        end
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Same blue, yellow and slope values at every position
    function automatic t_chunk uniform_chunk(logic axis, logic [31:0] blue, logic [31:0] yel,
                                             logic [31:0] bslope, logic [31:0] yslope);
        t_chunk c;
        c.axis               = axis;
        c.blue_start         = blue;
        c.blue_mid           = blue;
        c.blue_end           = blue;
        c.yellow_start       = yel;
        c.yellow_mid         = yel;
        c.yellow_end         = yel;
        c.blue_slope_start   = bslope;
        c.blue_slope_end     = bslope;
        c.yellow_slope_start = yslope;
        c.yellow_slope_end   = yslope;
        return c;
    endfunction

    function automatic logic [31:0] corner_val();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0000_0001;
            default: return $urandom();
        endcase
    endfunction

    // Coordinate within about +-32 of a center, in Q16.16
    function automatic logic [31:0] nearby(int center);
        return center + int'($urandom_range(0, 4194304)) - 2097152;
    endfunction

    function automatic int track_center();
        return int'($urandom_range(0, 536870912)) - 268435456;
    endfunction

    // Random request: mostly track-like, some full range, some corners
    function automatic t_chunk random_chunk();
        t_chunk c;
        int     kind;
        int     ctr;
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
            ctr = track_center();
            c.blue_start   = nearby(ctr);
            c.yellow_start = ($urandom_range(0, 7) == 0) ? c.blue_start : nearby(ctr);
            ctr = track_center();
            c.blue_mid     = nearby(ctr);
            c.yellow_mid   = ($urandom_range(0, 7) == 0) ? c.blue_mid : nearby(ctr);
            ctr = track_center();
            c.blue_end     = nearby(ctr);
            c.yellow_end   = ($urandom_range(0, 7) == 0) ? c.blue_end : nearby(ctr);
            c.blue_slope_start   = nearby(0);
            c.blue_slope_end     = nearby(0);
            c.yellow_slope_start = nearby(0);
            c.yellow_slope_end   = nearby(0);
        end else if (kind < 9) begin
            c = {1'b0, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        end else begin
            c = {1'b0, corner_val(), corner_val(), corner_val(), corner_val(), corner_val(),
                 corner_val(), corner_val(), corner_val(), corner_val(), corner_val()};
        end
        c.axis = $urandom_range(0, 1);
        return c;
    endfunction

    // Directed corners: extremes, zero gap, slopes alone, bit patterns
    function automatic t_chunk directed_chunk(int n);
        t_chunk c;
        logic   ax;
        logic [31:0] v;
        ax = n[0];
        v  = $urandom();
        case (n)
            0:  c = uniform_chunk(ax, 32'h0, 32'h0, 32'h0, 32'h0);
            1:  c = uniform_chunk(ax, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
            2:  c = uniform_chunk(ax, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
            3:  c = uniform_chunk(ax, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0);
            4:  c = uniform_chunk(ax, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0);
            5:  c = uniform_chunk(ax, v, v, $urandom(), $urandom());   // zero-length gap
            6:  c = uniform_chunk(ax, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0);
            7:  c = uniform_chunk(ax, 32'h0, 32'h0, 32'h0, 32'h8000_0000);
            8:  c = uniform_chunk(ax, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000);
            9:  c = uniform_chunk(ax, 32'h1, 32'h1, 32'h1, 32'h1);
            10: c = uniform_chunk(ax, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            11: c = uniform_chunk(ax, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
            12: c = uniform_chunk(ax, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
            13: c = uniform_chunk(ax, 32'h1, 32'h0, 32'h0, 32'h0);
            14: c = uniform_chunk(ax, 32'h0, 32'h1, 32'h0, 32'h0);
            default: begin
                c = random_chunk();
                c.axis = ax;
            end
        endcase
        return c;
    endfunction

    // Present one request and hold it until taken
    task automatic send_chunk(input t_chunk c, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start                <= 1'b1;
        i_axis               <= c.axis;
        i_blue_start         <= c.blue_start;
        i_yellow_start       <= c.yellow_start;
        i_blue_mid           <= c.blue_mid;
        i_yellow_mid         <= c.yellow_mid;
        i_blue_end           <= c.blue_end;
        i_yellow_end         <= c.yellow_end;
        i_blue_slope_start   <= c.blue_slope_start;
        i_blue_slope_end     <= c.blue_slope_end;
        i_yellow_slope_start <= c.yellow_slope_start;
        i_yellow_slope_end   <= c.yellow_slope_end;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_chunk(c);
    endtask

    // Stop sending and wait until every predicted piece has come out
    task automatic drain_pieces();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_pieces.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Write all three fractions plus a junk write to the unmapped index
    task automatic set_fractions(input logic [FRAC_W-1:0] s, input logic [FRAC_W-1:0] m,
                                 input logic [FRAC_W-1:0] e);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [FRAC_W-1:0]    val [4];
        idx = '{CFG_START_FRAC, CFG_MID_FRAC, CFG_END_FRAC, CFG_NO_REG};
        val = '{s, m, e, FRAC_W'($urandom())};
        for (int j = 0; j < 4; j++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx[j];
            i_cfg_data <= val[j];
            @(posedge i_clk);
            sb.write_fraction(idx[j], val[j]);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stimulus
    initial begin
        int burst_left;
        int gap;
        sb = new();
        burst_left = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed requests at the reset fractions
        for (int n = 0; n < DIRECTED_N; n++)
            send_chunk(directed_chunk(n), n % 3);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                drain_pieces();
                case (ph)
                    1: set_fractions('0, '0, '0);
                    2: set_fractions(FRAC_ONE, FRAC_ONE, FRAC_ONE);
                    3: set_fractions(FRAC_MAX, FRAC_MAX, FRAC_MAX);
                    4: set_fractions('0, FRAC_ONE, FRAC_MAX);
                    default: set_fractions(FRAC_W'($urandom_range(0, 131071)),
                                           FRAC_W'($urandom_range(0, 131071)),
                                           FRAC_W'($urandom_range(0, 131071)));
                endcase
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // occasional back-to-back bursts, otherwise random gaps
                if (burst_left == 0 && $urandom_range(0, 40) == 0)
                    burst_left = $urandom_range(20, 60);
                if (burst_left > 0) begin
                    burst_left--;
                    gap = 0;
                end else begin
                    gap = $urandom_range(0, 6);
                end
                send_chunk(random_chunk(), gap);
                if ($urandom_range(0, 99) == 0)
                    drain_pieces();
            end
        end

        drain_pieces();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
